@@ hdl/tts_pkg.sv @@
// ---------------------------------------------------------------------------
// Terminal cursor/scroll package
// Shared types, field widths and character codes of the text terminal unit.
// ---------------------------------------------------------------------------
package tts_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 11;
  localparam int COL_W  = 7;
  localparam int LINE_W = 5;

  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;

  typedef enum logic [OP_W-1:0] {
    OP_PUT  = 2'd0,
    OP_READ = 2'd1,
    OP_HOME = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_SCROLL,
    ST_CHAR,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_data;
    logic [COL_W-1:0]  cursor_column;
    logic [LINE_W-1:0] cursor_line;
    logic              did_scroll;
  } res_t;

endpackage

@@ hdl/tts_mem.sv @@
// ---------------------------------------------------------------------------
// Character store
// Single write port, single read port, read data registered.
// ---------------------------------------------------------------------------
module tts_mem #(
  parameter int Depth = tts_pkg::COLUMNS * tts_pkg::ROWS,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  tts_pkg::mem_cmd_t         cmd_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [tts_pkg::CHAR_W-1:0] wdata_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [tts_pkg::CHAR_W-1:0] rdata_o
);
  import tts_pkg::*;

  logic [CHAR_W-1:0] mem_q [Depth];
  logic [CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/tts_ctrl.sv @@
// ---------------------------------------------------------------------------
// Cursor and scroll sequencer
// Cursor state, circular row base, store clearing and per-transaction FSM.
// ---------------------------------------------------------------------------
module tts_ctrl #(
  parameter int Columns  = tts_pkg::COLUMNS,
  parameter int Rows     = tts_pkg::ROWS,
  parameter int TabWidth = tts_pkg::TAB_WIDTH,
  parameter int AddrW    = $clog2(Columns * Rows)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tts_pkg::OP_W-1:0]   op_i,
  input  logic [tts_pkg::CHAR_W-1:0] char_i,
  input  logic [tts_pkg::CELL_W-1:0] cell_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output tts_pkg::res_t              res_o,
  output tts_pkg::mem_cmd_t          cmd_o,
  output logic [AddrW-1:0]           waddr_o,
  output logic [tts_pkg::CHAR_W-1:0] wdata_o,
  output logic [AddrW-1:0]           raddr_o,
  input  logic [tts_pkg::CHAR_W-1:0] rdata_i
);
  import tts_pkg::*;

  localparam int CellCount = Columns * Rows;
  localparam int CW        = $clog2(Columns + 1);
  localparam int RW        = $clog2(Rows + 1);
  localparam int CntW      = $clog2(Columns);
  localparam int TabSteps  = (Columns + TabWidth - 1) / TabWidth;

  state_e            state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [CHAR_W-1:0] ch_q, ch_d;
  logic [CELL_W-1:0] cell_q, cell_d;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [AddrW-1:0]  base_q, base_d;
  logic [AddrW-1:0]  sweep_q, sweep_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              after_nl_q, after_nl_d;
  logic              scrolled_q, scrolled_d;
  logic [CHAR_W-1:0] data_q, data_d;

  logic [AddrW:0]    cur_lin, cell_lin, base_lin;
  logic [AddrW-1:0]  cur_addr, cell_addr, base_next;
  logic              cell_ok;
  logic [CW-1:0]     tab_next;

  // logical to physical: rows rotate around base_q
  assign cur_lin   = (AddrW+1)'(row_q * Columns) + (AddrW+1)'(col_q) + {1'b0, base_q};
  assign cur_addr  = (cur_lin >= (AddrW+1)'(CellCount)) ?
                     AddrW'(cur_lin - (AddrW+1)'(CellCount)) : AddrW'(cur_lin);
  assign cell_lin  = (AddrW+1)'(cell_q) + {1'b0, base_q};
  assign cell_addr = (cell_lin >= (AddrW+1)'(CellCount)) ?
                     AddrW'(cell_lin - (AddrW+1)'(CellCount)) : AddrW'(cell_lin);
  assign cell_ok   = (32'(cell_q) < CellCount);
  assign base_lin  = {1'b0, base_q} + (AddrW+1)'(Columns);
  assign base_next = (base_lin >= (AddrW+1)'(CellCount)) ?
                     AddrW'(base_lin - (AddrW+1)'(CellCount)) : AddrW'(base_lin);

  always_comb begin
    int cand;
    cand = Columns;
    for (int k = TabSteps; k >= 1; k--) begin
      if (k * TabWidth > int'(col_q)) cand = k * TabWidth;
    end
    tab_next = (cand > Columns) ? CW'(Columns) : CW'(cand);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      col_q      <= '0;
      row_q      <= '0;
      base_q     <= '0;
      sweep_q    <= '0;
      cnt_q      <= '0;
      after_nl_q <= 1'b0;
      scrolled_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_q      <= row_d;
      base_q     <= base_d;
      sweep_q    <= sweep_d;
      cnt_q      <= cnt_d;
      after_nl_q <= after_nl_d;
      scrolled_q <= scrolled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    ch_q   <= ch_d;
    cell_q <= cell_d;
    data_q <= data_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ch_d        = ch_q;
    cell_d      = cell_q;
    col_d       = col_q;
    row_d       = row_q;
    base_d      = base_q;
    sweep_d     = sweep_q;
    cnt_d       = cnt_q;
    after_nl_d  = after_nl_q;
    scrolled_d  = scrolled_q;
    data_d      = data_q;
    cmd_o       = '0;
    waddr_o     = sweep_q;
    wdata_o     = '0;
    raddr_o     = cell_addr;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.wr_en = 1'b1;
        sweep_d     = sweep_q + 1'b1;
        if (sweep_q == AddrW'(CellCount - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d       = op_i;
          ch_d       = char_i;
          cell_d     = cell_i;
          data_d     = '0;
          scrolled_d = 1'b0;
          after_nl_d = 1'b0;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (op_e'(op_q))
          OP_PUT: begin
            if (int'(col_q) >= Columns) begin
              col_d = '0;
              row_d = row_q + 1'b1;
            end
            state_d = ST_CHECK;
          end
          OP_READ: begin
            if (cell_ok) begin
              cmd_o.rd_en = 1'b1;
              state_d     = ST_READ;
            end else begin
              state_d = ST_DONE;
            end
          end
          OP_HOME: begin
            col_d   = '0;
            row_d   = '0;
            state_d = ST_DONE;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_CHECK: begin
        if (int'(row_q) >= Rows) begin
          // oldest row becomes the blank bottom row
          col_d      = '0;
          row_d      = RW'(Rows - 1);
          scrolled_d = 1'b1;
          sweep_d    = base_q;
          cnt_d      = '0;
          base_d     = base_next;
          state_d    = ST_SCROLL;
        end else begin
          state_d = after_nl_q ? ST_DONE : ST_CHAR;
        end
      end
      ST_SCROLL: begin
        cmd_o.wr_en = 1'b1;
        sweep_d     = sweep_q + 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CntW'(Columns - 1)) begin
          state_d = after_nl_q ? ST_DONE : ST_CHAR;
        end
      end
      ST_CHAR: begin
        priority if (ch_q == CH_NEWLINE) begin
          col_d      = '0;
          row_d      = row_q + 1'b1;
          after_nl_d = 1'b1;
          state_d    = ST_CHECK;
        end else if (ch_q == CH_TAB) begin
          col_d   = tab_next;
          state_d = ST_DONE;
        end else begin
          cmd_o.wr_en = 1'b1;
          waddr_o     = cur_addr;
          wdata_o     = ch_q;
          col_d       = col_q + 1'b1;
          state_d     = ST_DONE;
        end
      end
      ST_READ: begin
        data_d  = rdata_i;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  assign res_o.read_data     = data_q;
  assign res_o.cursor_column = COL_W'(col_q);
  assign res_o.cursor_line   = LINE_W'(row_q);
  assign res_o.did_scroll    = scrolled_q;

endmodule

@@ hdl/text_terminal_cursor_scroll_unit.sv @@
// ---------------------------------------------------------------------------
// Text terminal cursor and scroll unit
// Teletype engine with a character store, cursor tracking and line scroll.
// ---------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one command per transaction:
// put character, read screen cell or home cursor. Every command returns
// exactly one transaction on the output channel (out_valid_o/out_ready_i)
// with the read data, the cursor after the command and a scroll flag.
// One command is processed at a time. A read waits for the registered
// store read data, and each scroll sweeps the new bottom row to zero
// through the single write port of the store (rows rotate through a base
// pointer, so no data is moved). A newline after a pending wrap on the
// last row can scroll twice. in_ready_o returns in the cycle after the
// result leaves the sequencer. The result sits in an output register, so
// the next command is taken while the receiver stalls; a further result
// waits in the sequencer. After reset the store is cleared one cell per
// cycle, all Rows*Columns cells (2000 at 80x25), with in_ready_o low
// throughout.
// ---------------------------------------------------------------------------
module text_terminal_cursor_scroll_unit #(
  parameter int Columns  = tts_pkg::COLUMNS,
  parameter int Rows     = tts_pkg::ROWS,
  parameter int TabWidth = tts_pkg::TAB_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tts_pkg::OP_W-1:0]   in_operation_i,
  input  logic [tts_pkg::CHAR_W-1:0] in_char_code_i,
  input  logic [tts_pkg::CELL_W-1:0] in_cell_index_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tts_pkg::CHAR_W-1:0] out_read_data_o,
  output logic [tts_pkg::COL_W-1:0]  out_cursor_column_o,
  output logic [tts_pkg::LINE_W-1:0] out_cursor_line_o,
  output logic                       out_did_scroll_o
);
  import tts_pkg::*;

  localparam int CellCount = Columns * Rows;
  localparam int AddrW     = $clog2(CellCount);

  mem_cmd_t          cmd;
  logic [AddrW-1:0]  waddr, raddr;
  logic [CHAR_W-1:0] wdata, rdata;
  logic              res_valid, res_ready;
  res_t              res;
  res_t              out_q;
  logic              out_valid_q;

  tts_ctrl #(
    .Columns (Columns),
    .Rows    (Rows),
    .TabWidth(TabWidth),
    .AddrW   (AddrW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (in_operation_i),
    .char_i     (in_char_code_i),
    .cell_i     (in_cell_index_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .cmd_o      (cmd),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  tts_mem #(
    .Depth(CellCount),
    .AddrW(AddrW)
  ) u_mem (
    .clk_i  (clk_i),
    .cmd_i  (cmd),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_read_data_o     = out_q.read_data;
  assign out_cursor_column_o = out_q.cursor_column;
  assign out_cursor_line_o   = out_q.cursor_line;
  assign out_did_scroll_o    = out_q.did_scroll;

  a_line_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_cursor_line_o) <= Rows - 1))
    else $error("cursor line beyond last row");

  a_scroll_last_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_did_scroll_o) |-> (int'(out_cursor_line_o) == Rows - 1))
    else $error("scroll did not leave cursor on last row");

  a_no_accept_with_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !in_ready_o)
    else $error("command accepted while a result is pending");

endmodule

@@ tb/text_terminal_cursor_scroll_unit_tb.sv @@
// ---------------------------------------------------------------------------
// Text terminal cursor and scroll unit testbench
// Sends put, read, home and unused commands through the input channel and
// checks every result field against an in-bench model of the character
// store and cursor. Sender and receiver idle at random; the receiver holds
// off once for a long stretch and the sender drains once between phases.
// ---------------------------------------------------------------------------
module text_terminal_cursor_scroll_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tts_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 600;
  localparam int HOLD_AFTER = 150;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] code;
    logic [CELL_W-1:0] cell_ix;
  } term_cmd_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [OP_W-1:0]   in_operation_i = '0;
  logic [CHAR_W-1:0] in_char_code_i = '0;
  logic [CELL_W-1:0] in_cell_index_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CHAR_W-1:0] out_read_data_o;
  logic [COL_W-1:0]  out_cursor_column_o;
  logic [LINE_W-1:0] out_cursor_line_o;
  logic              out_did_scroll_o;

  // model of the store and cursor
  logic [CHAR_W-1:0] screen_model [CELLS];
  int                cur_col;
  int                cur_row;

  term_cmd_t commands_q [$];
  res_t      pending_reports [$];
  term_cmd_t cur_cmd;

  int send_gap;
  int stall_left;
  int idle_cycles = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  bit hold_done = 1'b0;
  bit drive_next;
  res_t seen;
  res_t want;

  int total_queued = 0;
  int results_seen = 0;
  int mismatches = 0;
  int n_put = 0, n_read = 0, n_home = 0, n_unused = 0;
  int n_scrolled = 0, n_double = 0;

  text_terminal_cursor_scroll_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .in_operation_i     (in_operation_i),
    .in_char_code_i     (in_char_code_i),
    .in_cell_index_i    (in_cell_index_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_read_data_o    (out_read_data_o),
    .out_cursor_column_o(out_cursor_column_o),
    .out_cursor_line_o  (out_cursor_line_o),
    .out_did_scroll_o   (out_did_scroll_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = '0;
    cur_row = ROWS - 1;
    cur_col = 0;
  endfunction

  function automatic res_t apply_command(term_cmd_t c);
    res_t r;
    int   scrolls;
    int   nxt;
    int   idx;
    r = '0;
    scrolls = 0;
    case (c.op)
      OP_PUT: begin
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          scroll_screen();
          scrolls++;
        end
        if (c.code == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
          if (cur_row >= ROWS) begin
            scroll_screen();
            scrolls++;
          end
        end else if (c.code == CH_TAB) begin
          nxt = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
          cur_col = (nxt > COLUMNS) ? COLUMNS : nxt;
        end else begin
          idx = cur_row * COLUMNS + cur_col;
          if (idx < CELLS) screen_model[idx] = c.code;
          cur_col++;
        end
      end
      OP_READ: begin
        if (int'(c.cell_ix) < CELLS) r.read_data = screen_model[c.cell_ix];
      end
      OP_HOME: begin
        cur_col = 0;
        cur_row = 0;
      end
      default: ;
    endcase
    if (scrolls > 1) n_double++;
    r.cursor_column = COL_W'(cur_col);
    r.cursor_line   = LINE_W'(cur_row);
    r.did_scroll    = (scrolls > 0);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [CELL_W-1:0] pick_cell();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return CELL_W'($urandom_range(0, CELLS - 1));
    if (r < 9) return CELL_W'($urandom_range(CELLS - COLUMNS, CELLS - 1));
    return CELL_W'($urandom_range(0, 2047));
  endfunction

  task automatic push_cmd(logic [OP_W-1:0] op, logic [CHAR_W-1:0] code,
                          logic [CELL_W-1:0] cell_ix);
    term_cmd_t c;
    c.op = op;
    c.code = code;
    c.cell_ix = cell_ix;
    commands_q.push_back(c);
    total_queued++;
  endtask

  // home, walk to the last row, fill it to a pending wrap, then newline
  task automatic push_bottom_wrap();
    push_cmd(OP_HOME, CHAR_W'($urandom), pick_cell());
    repeat (ROWS - 1) push_cmd(OP_PUT, CH_NEWLINE, pick_cell());
    repeat (COLUMNS) push_cmd(OP_PUT, CHAR_W'($urandom_range(32, 126)), pick_cell());
    push_cmd(OP_PUT, CH_NEWLINE, pick_cell());
  endtask

  task automatic add_random_traffic(int n);
    int start;
    int kind;
    start = total_queued;
    push_bottom_wrap();
    while (total_queued - start < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        repeat ($urandom_range(1, 90)) push_cmd(OP_PUT, CHAR_W'($urandom), pick_cell());
        if ($urandom_range(0, 9) < 7) push_cmd(OP_PUT, CH_NEWLINE, pick_cell());
      end else if (kind < 48) begin
        push_cmd(OP_PUT, CH_NEWLINE, pick_cell());
        repeat (COLUMNS) push_cmd(OP_PUT, CHAR_W'($urandom), pick_cell());
        push_cmd(OP_PUT, CH_NEWLINE, pick_cell());
      end else if (kind < 50) begin
        push_bottom_wrap();
      end else if (kind < 63) begin
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 3) == 0) push_cmd(OP_PUT, CHAR_W'($urandom), pick_cell());
          else push_cmd(OP_PUT, CH_TAB, pick_cell());
        end
      end else if (kind < 83) begin
        repeat ($urandom_range(1, 4)) push_cmd(OP_READ, CHAR_W'($urandom), pick_cell());
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 30)) push_cmd(OP_PUT, CH_NEWLINE, pick_cell());
      end else if (kind < 91) begin
        push_cmd(OP_HOME, CHAR_W'($urandom), pick_cell());
      end else if (kind < 94) begin
        push_cmd(OP_UNUSED, CHAR_W'($urandom), CELL_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 6))
          push_cmd(OP_W'($urandom_range(0, 3)), CHAR_W'($urandom), CELL_W'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (commands_q.size() != 0 || in_valid_i || pending_reports.size() != 0)
      @(posedge clk_i);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      drive_next = !in_valid_i;
      if (in_valid_i && in_ready_o) begin
        pending_reports.push_back(apply_command(cur_cmd));
        case (cur_cmd.op)
          OP_PUT:  n_put++;
          OP_READ: n_read++;
          OP_HOME: n_home++;
          default: n_unused++;
        endcase
        drive_next = 1'b1;
      end
      if (drive_next) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (commands_q.size() > 0) begin
          cur_cmd = commands_q.pop_front();
          in_valid_i      <= 1'b1;
          in_operation_i  <= cur_cmd.op;
          in_char_code_i  <= cur_cmd.code;
          in_cell_index_i <= cur_cmd.cell_ix;
          if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        seen.read_data     = out_read_data_o;
        seen.cursor_column = out_cursor_column_o;
        seen.cursor_line   = out_cursor_line_o;
        seen.did_scroll    = out_did_scroll_o;
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing outstanding: data %0d col %0d line %0d scroll %0d",
                     $realtime, seen.read_data, seen.cursor_column, seen.cursor_line,
                     seen.did_scroll);
        end else begin
          want = pending_reports.pop_front();
          if (want.did_scroll) n_scrolled++;
          if (seen != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d: data %0d/%0d col %0d/%0d line %0d/%0d scroll %0d/%0d",
                       $realtime, results_seen, seen.read_data, want.read_data,
                       seen.cursor_column, want.cursor_column, seen.cursor_line,
                       want.cursor_line, seen.did_scroll, want.did_scroll);
          end
        end
      end
      // one long hold-off so the unit backs up and stalls its input
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!recv_calm && $urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles without a transaction", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) screen_model[i] = '0;
    cur_col = 0;
    cur_row = 0;

    // directed: store edges, out-of-range reads, byte extremes, tabs to the edge
    push_cmd(OP_READ, 8'h00, 11'd0);
    push_cmd(OP_READ, 8'hff, 11'(CELLS - 1));
    push_cmd(OP_READ, 8'h00, 11'(CELLS));
    push_cmd(OP_READ, 8'hff, 11'h7ff);
    push_cmd(OP_PUT, 8'hff, 11'h7ff);
    push_cmd(OP_PUT, 8'h00, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'd1);
    push_cmd(OP_UNUSED, 8'hff, 11'h7ff);
    push_cmd(OP_PUT, 8'h41, 11'd0);
    push_cmd(OP_PUT, CH_NEWLINE, 11'd0);
    push_cmd(OP_HOME, 8'hff, 11'h7ff);
    repeat (COLUMNS / TAB_WIDTH) push_cmd(OP_PUT, CH_TAB, 11'd0);
    push_cmd(OP_PUT, 8'h5a, 11'd0);
    push_cmd(OP_READ, 8'h00, 11'(COLUMNS));

    add_random_traffic(400);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait_drained();
    add_random_traffic(400);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d commands: %0d put, %0d read, %0d home, %0d unused opcode",
             n_put + n_read + n_home + n_unused, n_put, n_read, n_home, n_unused);
    $display("Checked %0d results, %0d with a scroll, %0d puts scrolling twice",
             results_seen, n_scrolled, n_double);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_reports.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/tts_pkg.sv
hdl/tts_mem.sv
hdl/tts_ctrl.sv
hdl/text_terminal_cursor_scroll_unit.sv
tb/text_terminal_cursor_scroll_unit_tb.sv
